[sv/srgb_to_cie_xy_unit_defines.svh]
// assertion macros for the srgb to cie xy top level
`ifndef SRGB_TO_CIE_XY_UNIT_DEFINES_SVH
`define SRGB_TO_CIE_XY_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define S2XY_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("s2xy assertion failed");

// next-cycle implication, disabled during reset
`define S2XY_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("s2xy assertion failed");

`endif

[sv/s2xy_pkg.sv]
// types, constants and the gamma table for the srgb to cie xy unit
package s2xy_pkg;

  localparam int unsigned LIN_W = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned XYZ_W = 33;
  localparam int unsigned SUM_W = 34;

  typedef logic [LIN_W-1:0] gamma_rom_t [256];

  typedef struct packed {
    logic [XYZ_W-1:0] x;
    logic [XYZ_W-1:0] y;
    logic [SUM_W-1:0] s;
  } s2xy_xys_t;

  localparam logic [15:0] XYZ_COEF [3][3] = '{
    '{16'd27027, 16'd23435, 16'd11829},
    '{16'd13932, 16'd46869, 16'd4732},
    '{16'd1265,  16'd7811,  16'd62292}
  };

  // inverse srgb gamma in q0.16, evaluated at elaboration
  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t rom;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned lin;
    longint unsigned q;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        q = (longint'(c) * 64'd6553600 + 64'd164730) / 64'd329460;
      end else begin
        u = ((longint'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        u2 = (u * u) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p = mid;
          for (int k = 0; k < 4; k++) begin
            p = (p * mid) >> 30;
          end
          if (p <= u2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        lin = (u2 * lo) >> 30;
        q = (lin + 64'd8192) >> 14;
        if (q > 64'd65535) q = 64'd65535;
      end
      rom[c] = q[LIN_W-1:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage

[sv/s2xy_matrix.sv]
// gamma lookup and 3x3 matrix, four register stages
module s2xy_matrix import s2xy_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  output s2xy_xys_t  xys_o
);

  logic [3:0] v_q;
  logic [LIN_W-1:0] lin_q [3];
  logic [PROD_W-1:0] prod_q [3][3];
  logic [XYZ_W-1:0] comp_q [3];
  s2xy_xys_t xys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q[0] <= GAMMA_ROM[red_i];
      lin_q[1] <= GAMMA_ROM[green_i];
      lin_q[2] <= GAMMA_ROM[blue_i];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= PROD_W'(XYZ_COEF[i][j]) * PROD_W'(lin_q[j]);
        end
        comp_q[i] <= XYZ_W'(prod_q[i][0]) + XYZ_W'(prod_q[i][1]) + XYZ_W'(prod_q[i][2]);
      end
      xys_q.x <= comp_q[0];
      xys_q.y <= comp_q[1];
      xys_q.s <= SUM_W'(comp_q[0]) + SUM_W'(comp_q[1]) + SUM_W'(comp_q[2]);
    end
  end

  assign valid_o = v_q[3];
  assign xys_o = xys_q;

endmodule

[sv/s2xy_div.sv]
// pipelined restoring divider for x/s and y/s, one quotient bit per stage
module s2xy_div import s2xy_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  s2xy_xys_t            xys_i,
  output logic                 valid_o,
  output logic                 black_o,
  output logic [FRAC_BITS-1:0] qx_o,
  output logic [FRAC_BITS-1:0] qy_o
);

  localparam int unsigned REM_W = SUM_W + 1;

  logic [FRAC_BITS-1:0] v_q;
  logic [FRAC_BITS-1:0] blk_q;
  logic [SUM_W-1:0] s_q [FRAC_BITS];
  logic [REM_W-1:0] rx_q [FRAC_BITS];
  logic [REM_W-1:0] ry_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] qx_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] qy_q [FRAC_BITS];

  logic [REM_W-1:0] rx_d [FRAC_BITS];
  logic [REM_W-1:0] ry_d [FRAC_BITS];
  logic [FRAC_BITS-1:0] qx_d [FRAC_BITS];
  logic [FRAC_BITS-1:0] qy_d [FRAC_BITS];
  logic [SUM_W-1:0] s_d [FRAC_BITS];

  // each stage shifts the partial remainder and subtracts s when it fits
  always_comb begin
    logic [REM_W-1:0] sx;
    logic [REM_W-1:0] sy;
    logic [REM_W-1:0] px;
    logic [REM_W-1:0] py;
    logic [FRAC_BITS-1:0] pqx;
    logic [FRAC_BITS-1:0] pqy;
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (k == 0) begin
        px = REM_W'(xys_i.x);
        py = REM_W'(xys_i.y);
        pqx = '0;
        pqy = '0;
        s_d[k] = xys_i.s;
      end else begin
        px = rx_q[k-1];
        py = ry_q[k-1];
        pqx = qx_q[k-1];
        pqy = qy_q[k-1];
        s_d[k] = s_q[k-1];
      end
      sx = px << 1;
      sy = py << 1;
      if (sx >= REM_W'(s_d[k])) begin
        rx_d[k] = sx - REM_W'(s_d[k]);
        qx_d[k] = {pqx[FRAC_BITS-2:0], 1'b1};
      end else begin
        rx_d[k] = sx;
        qx_d[k] = {pqx[FRAC_BITS-2:0], 1'b0};
      end
      if (sy >= REM_W'(s_d[k])) begin
        ry_d[k] = sy - REM_W'(s_d[k]);
        qy_d[k] = {pqy[FRAC_BITS-2:0], 1'b1};
      end else begin
        ry_d[k] = sy;
        qy_d[k] = {pqy[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FRAC_BITS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= {blk_q[FRAC_BITS-2:0], (xys_i.s == '0)};
      for (int k = 0; k < FRAC_BITS; k++) begin
        s_q[k] <= s_d[k];
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
      end
    end
  end

  assign valid_o = v_q[FRAC_BITS-1];
  assign black_o = blk_q[FRAC_BITS-1];
  assign qx_o = qx_q[FRAC_BITS-1];
  assign qy_o = qy_q[FRAC_BITS-1];

endmodule

[sv/srgb_to_cie_xy_unit.sv]
// srgb to cie xy chromaticity unit, top level
// Converts one 8-bit sRGB pixel per clock to CIE 1931 xy chromaticity in
// unsigned fixed point with FRAC_BITS fraction bits, saturated to 16 bits.
// Each channel is linearized by a constant 256-entry inverse gamma table,
// the sRGB-to-XYZ matrix gives X, Y, Z, and x = X/S, y = Y/S with S = X+Y+Z
// come from a pipelined restoring divider. Throughput is one item per cycle
// while not stalled; the steps are gamma lookup, products, row sums, total,
// then one quotient bit per stage. A black pixel gives x = y = 0 and
// black_input_o = 1. The whole pipeline advances together and holds while the
// output item waits under out_stall_i.
module srgb_to_cie_xy_unit import s2xy_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] chroma_x_o,
  output logic [15:0] chroma_y_o,
  output logic        black_input_o
);

  `include "srgb_to_cie_xy_unit_defines.svh"

  localparam int unsigned QW = (FRAC_BITS > 16) ? FRAC_BITS : 16;

  logic adv;
  logic mat_valid;
  s2xy_xys_t mat_xys;
  logic div_valid;
  logic div_black;
  logic [FRAC_BITS-1:0] qx;
  logic [FRAC_BITS-1:0] qy;
  logic [QW-1:0] qx_ext;
  logic [QW-1:0] qy_ext;

  // everything moves unless a finished item is held at the output
  assign adv = !div_valid || !out_stall_i;
  assign in_stall_o = !adv;

  s2xy_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (mat_valid),
    .xys_o   (mat_xys)
  );

  s2xy_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (mat_valid),
    .xys_i   (mat_xys),
    .valid_o (div_valid),
    .black_o (div_black),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  // saturate to 16 bits, force zero for a black pixel
  assign qx_ext = QW'(qx);
  assign qy_ext = QW'(qy);
  assign chroma_x_o = div_black ? 16'd0 :
                      (qx_ext > QW'(16'hFFFF)) ? 16'hFFFF : qx_ext[15:0];
  assign chroma_y_o = div_black ? 16'd0 :
                      (qy_ext > QW'(16'hFFFF)) ? 16'hFFFF : qy_ext[15:0];
  assign black_input_o = div_black;
  assign out_valid_o = div_valid;

  `S2XY_ASSERT_IMP(a_black_zero, out_valid_o && black_input_o,
    chroma_x_o == 16'd0 && chroma_y_o == 16'd0)
  `S2XY_ASSERT_IMP(a_empty_accepts, !out_valid_o, !in_stall_o)
  `S2XY_ASSERT_IMP(a_stall_backs_up, out_valid_o && out_stall_i, in_stall_o)

endmodule
